### sv/nrzi_fifo_bit_transmitter_macros.svh
// ----------------------------------------------------------------------------
// NRZI FIFO bit transmitter assertion macros
// Shared concurrent check forms, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef NRZI_FIFO_BIT_TRANSMITTER_MACROS_SVH
`define NRZI_FIFO_BIT_TRANSMITTER_MACROS_SVH

// same-cycle implication
`define NFBT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NFBT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/nfbt_pkg.sv
// ----------------------------------------------------------------------------
// NRZI FIFO bit transmitter package
// Item types, operation codes and fixed constants shared by the front end, back end and top modules.
// ----------------------------------------------------------------------------
`default_nettype none

package nfbt_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam logic [2:0] LAST_BIT = 3'd7;

  typedef enum logic [1:0] {
    OP_WRITE = 2'b01,
    OP_TICK  = 2'b10
  } op_kind_t;

  typedef struct packed {
    logic              mode;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } in_item_t;

  typedef struct packed {
    logic line_level;
    logic tx_active;
    logic done_pulse;
    logic write_dropped;
  } out_item_t;

  typedef struct packed {
    op_kind_t          kind;
    logic [BYTE_W-1:0] data;
    logic              last;
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } queue_head_t;

endpackage

`default_nettype wire

### sv/nfbt_ram.sv
// ----------------------------------------------------------------------------
// NRZI FIFO bit transmitter RAM
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module nfbt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

### sv/nfbt_front.sv
// ----------------------------------------------------------------------------
// NRZI FIFO bit transmitter front end
// Accepts input items, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module nfbt_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire nfbt_pkg::in_item_t   in_data,
  output nfbt_pkg::queue_head_t     q_head,
  input  wire logic                 q_pop
);

  nfbt_pkg::op_t slot_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          push;
  logic          pop;
  nfbt_pkg::op_t in_op;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && (cnt_r != 2'd0);

  always_comb begin
    in_op.kind = in_data.mode ? nfbt_pkg::OP_TICK : nfbt_pkg::OP_WRITE;
    in_op.data = in_data.data_byte;
    in_op.last = in_data.last_byte;
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= in_op;
    end
  end

  assign q_head = '{valid: (cnt_r != 2'd0), op: slot_r[rd_ptr_r]};

endmodule

`default_nettype wire

### sv/nfbt_back.sv
// ----------------------------------------------------------------------------
// NRZI FIFO bit transmitter back end
// Runs queued operations against the byte buffer and the NRZI line state.
// ----------------------------------------------------------------------------
`default_nettype none
`include "nrzi_fifo_bit_transmitter_macros.svh"

module nfbt_back #(
  parameter int unsigned BUFFER_DEPTH = 64,
  localparam int unsigned PTR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1,
  localparam int unsigned CNT_W = $clog2(BUFFER_DEPTH + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire nfbt_pkg::queue_head_t q_head,
  output logic                       q_pop,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output nfbt_pkg::out_item_t        out_data
);

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(BUFFER_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(BUFFER_DEPTH);

  logic [PTR_W-1:0]                rp_r, rp_nxt;
  logic [PTR_W-1:0]                wp_r, wp_nxt;
  logic [CNT_W-1:0]                count_r, count_nxt;
  logic [2:0]                      bit_r, bit_nxt;
  logic                            level_r, level_nxt;
  logic                            active_r, active_nxt;
  logic [nfbt_pkg::BYTE_W-1:0]     head_r;
  logic                            head_valid_r, head_valid_nxt;
  logic                            rd_pend_r;
  logic [nfbt_pkg::BYTE_W-1:0]     rd_data;
  logic                            fetch;
  logic                            out_free;
  logic                            exec;
  logic                            is_write;
  logic                            is_tick;
  logic                            full;
  logic                            mem_we;
  logic                            done;
  logic                            dropped;
  logic                            out_valid_r, out_valid_nxt;
  nfbt_pkg::out_item_t             out_data_r;

  assign is_write = (q_head.op.kind == nfbt_pkg::OP_WRITE);
  assign is_tick  = (q_head.op.kind == nfbt_pkg::OP_TICK);
  assign out_free = !out_valid_r || !out_stall;
  assign exec     = q_head.valid && out_free &&
                    (is_write || !active_r || head_valid_r);
  assign q_pop    = exec;
  assign full     = (count_r == CNT_FULL);
  assign mem_we   = exec && is_write && !full;
  assign fetch    = !head_valid_r && !rd_pend_r && (count_r != '0);

  nfbt_ram #(
    .WIDTH (nfbt_pkg::BYTE_W),
    .DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wp_r),
    .wdata (q_head.op.data),
    .re    (fetch),
    .raddr (rp_r),
    .rdata (rd_data)
  );

  always_comb begin
    rp_nxt         = rp_r;
    wp_nxt         = wp_r;
    count_nxt      = count_r;
    bit_nxt        = bit_r;
    level_nxt      = level_r;
    active_nxt     = active_r;
    head_valid_nxt = head_valid_r || rd_pend_r;
    done           = 1'b0;
    dropped        = 1'b0;
    if (exec && is_write) begin
      if (full) begin
        dropped = 1'b1;
      end else begin
        wp_nxt    = (wp_r == PTR_LAST) ? '0 : wp_r + PTR_W'(1);
        count_nxt = count_r + CNT_W'(1);
      end
      if (q_head.op.last && (count_nxt != '0)) begin
        active_nxt = 1'b1;
      end
    end else if (exec && is_tick && active_r) begin
      level_nxt = level_r ^ ~head_r[bit_r];
      if (bit_r == nfbt_pkg::LAST_BIT) begin
        bit_nxt        = 3'd0;
        rp_nxt         = (rp_r == PTR_LAST) ? '0 : rp_r + PTR_W'(1);
        head_valid_nxt = 1'b0;
        count_nxt      = count_r - CNT_W'(1);
        if (count_nxt == '0) begin
          active_nxt = 1'b0;
          done       = 1'b1;
        end
      end else begin
        bit_nxt = bit_r + 3'd1;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (exec) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r         <= '0;
      wp_r         <= '0;
      count_r      <= '0;
      bit_r        <= 3'd0;
      level_r      <= 1'b0;
      active_r     <= 1'b0;
      head_valid_r <= 1'b0;
      rd_pend_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      rp_r         <= rp_nxt;
      wp_r         <= wp_nxt;
      count_r      <= count_nxt;
      bit_r        <= bit_nxt;
      level_r      <= level_nxt;
      active_r     <= active_nxt;
      head_valid_r <= head_valid_nxt;
      rd_pend_r    <= fetch;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pend_r) begin
      head_r <= rd_data;
    end
    if (exec) begin
      out_data_r.line_level    <= level_nxt;
      out_data_r.tx_active     <= active_nxt;
      out_data_r.done_pulse    <= done;
      out_data_r.write_dropped <= dropped;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `NFBT_ASSERT_SAME(a_active_has_bytes, active_r, count_r != '0,
    "transmitter active with empty buffer")
  `NFBT_ASSERT_SAME(a_count_bound, 1'b1, count_r <= CNT_FULL,
    "fill count beyond buffer depth")
  `NFBT_ASSERT_NEXT(a_fetch_lands, rd_pend_r, head_valid_r || count_r == '0,
    "head fetch did not load head byte")
  `NFBT_ASSERT_NEXT(a_done_stops, exec && done, !active_r && count_r == '0,
    "done given while bytes remain")

endmodule

`default_nettype wire

### sv/nrzi_fifo_bit_transmitter.sv
// ----------------------------------------------------------------------------
// NRZI FIFO bit transmitter
// Byte FIFO feeding an NRZI line encoder, one result item per input item.
// ----------------------------------------------------------------------------
// Input items carry mode, data_byte and last_byte on in_data; a write queues a
// byte (a last write starts sending), a tick sends one bit of the head byte,
// least significant bit first, toggling the line on a zero bit.
// Each input item yields one result item on out_data: line level, active flag,
// done pulse on the tick that drains the buffer, and a drop flag for a write
// that found the buffer full.
// Results are registered: an item passes through the two-entry queue and then the output register.
// Throughput: one item per cycle while the output is not stalled. After a byte is retired,
// the next tick waits while the new head byte is read from the buffer RAM, whose
// read data is registered.
// A two-entry queue parts the input side from the execution side; in_stall
// rises only when that queue is full. A stalled result holds in the output
// register while the queue keeps taking items.
// Reset (rst_n low, synchronous) empties the buffer, clears the pointers,
// the line level and the active flag. Buffer contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module nrzi_fifo_bit_transmitter #(
  parameter int unsigned BUFFER_DEPTH = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire nfbt_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output nfbt_pkg::out_item_t      out_data
);

  nfbt_pkg::queue_head_t q_head;
  logic                  q_pop;

  nfbt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_head   (q_head),
    .q_pop    (q_pop)
  );

  nfbt_back #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### tb/tb_nrzi_fifo_bit_transmitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NRZI FIFO bit transmitter testbench
// Drives write and tick items through the byte FIFO and checks every result
// item, field by field, against a cycle-free model of the buffer and the line
// encoder, or against the table values for the fixed directed rows. A short
// directed table comes first, then random byte strings, a fill past the buffer
// depth, broken strings and noise, with idle bursts on both channels.
// ----------------------------------------------------------------------------
module tb_nrzi_fifo_bit_transmitter;

  localparam int unsigned BUF_DEPTH = 64;
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_TICK  = 1'b1;
  localparam int DIR_N = 20;
  localparam int RAND_TARGET = 620;
  localparam int CALM_TAIL = 60;

  typedef struct packed {
    logic       mode;
    logic [7:0] data;
    logic       last;
    logic       fixed;
    logic [3:0] want;
  } dir_row_t;

  // want = {line_level, tx_active, done_pulse, write_dropped}
  localparam dir_row_t DIR_ROWS [0:DIR_N-1] = '{
    {MODE_TICK,  8'h00, 1'b1, 1'b1, 4'b0000},
    {MODE_WRITE, 8'h00, 1'b0, 1'b1, 4'b0000},
    {MODE_WRITE, 8'hFF, 1'b1, 1'b1, 4'b0100},
    {MODE_TICK,  8'hFF, 1'b0, 1'b0, 4'b0000},
    {MODE_TICK,  8'h00, 1'b1, 1'b0, 4'b0000},
    {MODE_TICK,  8'hA5, 1'b0, 1'b0, 4'b0000},
    {MODE_TICK,  8'h5A, 1'b1, 1'b0, 4'b0000},
    {MODE_TICK,  8'h00, 1'b0, 1'b0, 4'b0000},
    {MODE_TICK,  8'hFF, 1'b1, 1'b0, 4'b0000},
    {MODE_TICK,  8'h0F, 1'b0, 1'b0, 4'b0000},
    {MODE_TICK,  8'hF0, 1'b1, 1'b0, 4'b0000},
    {MODE_TICK,  8'h00, 1'b0, 1'b1, 4'b0100},
    {MODE_TICK,  8'h00, 1'b0, 1'b1, 4'b0100},
    {MODE_TICK,  8'h00, 1'b0, 1'b1, 4'b0100},
    {MODE_TICK,  8'h00, 1'b0, 1'b1, 4'b0100},
    {MODE_TICK,  8'h00, 1'b0, 1'b1, 4'b0100},
    {MODE_TICK,  8'h00, 1'b0, 1'b1, 4'b0100},
    {MODE_TICK,  8'h00, 1'b0, 1'b1, 4'b0100},
    {MODE_TICK,  8'h00, 1'b0, 1'b1, 4'b0010},
    {MODE_TICK,  8'hFF, 1'b1, 1'b1, 4'b0000}
  };

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  nfbt_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_stall;
  nfbt_pkg::out_item_t out_data;

  always #6 clk = ~clk;

  nrzi_fifo_bit_transmitter u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  logic [7:0]  tx_byte_mem [BUF_DEPTH];
  int unsigned tx_rd_ptr = 0;
  int unsigned tx_wr_ptr = 0;
  int unsigned tx_fill = 0;
  logic [2:0]  tx_bit_pos = 3'd0;
  logic        tx_line = 1'b0;
  logic        tx_active_q = 1'b0;

  nfbt_pkg::in_item_t  stim_items [$];
  bit                  stim_fixed [$];
  nfbt_pkg::out_item_t stim_fixed_val [$];
  nfbt_pkg::out_item_t pending_results [$];
  int unsigned         accepted_cnt = 0;
  int                  pause_idx = -1;
  int                  error_cnt = 0;
  bit                  no_idle = 1'b0;
  nfbt_pkg::out_item_t head_result;
  nfbt_pkg::out_item_t pred_result;

  function automatic nfbt_pkg::out_item_t nrzi_next_result(nfbt_pkg::in_item_t item);
    nfbt_pkg::out_item_t res;
    logic                sent;
    res = '0;
    if (item.mode == MODE_WRITE) begin
      if (tx_fill >= BUF_DEPTH) begin
        res.write_dropped = 1'b1;
      end else begin
        tx_byte_mem[tx_wr_ptr] = item.data_byte;
        tx_wr_ptr = (tx_wr_ptr + 1) % BUF_DEPTH;
        tx_fill++;
      end
      if (item.last_byte && tx_fill != 0) tx_active_q = 1'b1;
    end else if (tx_active_q) begin
      sent = tx_byte_mem[tx_rd_ptr][tx_bit_pos];
      if (!sent) tx_line = ~tx_line;
      if (tx_bit_pos == nfbt_pkg::LAST_BIT) begin
        tx_bit_pos = 3'd0;
        tx_rd_ptr = (tx_rd_ptr + 1) % BUF_DEPTH;
        if (tx_fill != 0) tx_fill--;
        if (tx_fill == 0) begin
          tx_active_q = 1'b0;
          res.done_pulse = 1'b1;
        end
      end else begin
        tx_bit_pos = tx_bit_pos + 3'd1;
      end
    end
    res.line_level = tx_line;
    res.tx_active = tx_active_q;
    return res;
  endfunction

  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic push_item(logic mode, logic [7:0] data, logic last);
    nfbt_pkg::in_item_t item;
    item.mode = mode;
    item.data_byte = data;
    item.last_byte = last;
    stim_items.push_back(item);
    stim_fixed.push_back(1'b0);
    stim_fixed_val.push_back('0);
  endtask

  task automatic check_field(string name, logic want, logic got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0b, actual %0b", $time, name, want, got);
      error_cnt++;
    end
  endtask

  // predict on every accepted input item
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      pred_result = nrzi_next_result(in_data);
      if (stim_fixed[accepted_cnt])
        pending_results.push_back(stim_fixed_val[accepted_cnt]);
      else
        pending_results.push_back(pred_result);
      accepted_cnt++;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result item, expected none, actual %b", $time, out_data);
        error_cnt++;
      end else begin
        head_result = pending_results.pop_front();
        check_field("line_level", head_result.line_level, out_data.line_level);
        check_field("tx_active", head_result.tx_active, out_data.tx_active);
        check_field("done_pulse", head_result.done_pulse, out_data.done_pulse);
        check_field("write_dropped", head_result.write_dropped, out_data.write_dropped);
      end
    end
  end

  // receiver stalls
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!no_idle && $urandom_range(0, 9) < 2) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else if (!no_idle && $urandom_range(0, 29) == 0) begin
        repeat ($urandom_range(20, 60)) @(posedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int n_bytes;
    int n_ticks;
    int idx;
    int gap;
    int calm_left;
    bit filled;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    filled = 1'b0;
    calm_left = 0;

    for (int i = 0; i < DIR_N; i++) begin
      push_item(DIR_ROWS[i].mode, DIR_ROWS[i].data, DIR_ROWS[i].last);
      stim_fixed[i] = DIR_ROWS[i].fixed;
      stim_fixed_val[i] = nfbt_pkg::out_item_t'(DIR_ROWS[i].want);
    end

    while (stim_items.size() - DIR_N < RAND_TARGET) begin
      if (!filled && stim_items.size() - DIR_N >= 30) begin
        // overrun the buffer, start on a dropped last write, then drain
        filled = 1'b1;
        pause_idx = stim_items.size();
        n_bytes = BUF_DEPTH + $urandom_range(2, 5);
        for (int k = 0; k < n_bytes; k++)
          push_item(MODE_WRITE, pick_byte(), k >= BUF_DEPTH);
        for (int k = 0; k < BUF_DEPTH * 8 + 11; k++)
          push_item(MODE_TICK, pick_byte(), 1'($urandom_range(0, 1)));
      end else if ($urandom_range(0, 9) < 7) begin
        n_bytes = $urandom_range(1, 4);
        for (int k = 0; k < n_bytes; k++)
          push_item(MODE_WRITE, pick_byte(),
                    (k == n_bytes - 1) ? ($urandom_range(0, 7) != 0) : 1'b0);
        n_ticks = 8 * n_bytes + $urandom_range(0, 3);
        if ($urandom_range(0, 7) == 0) n_ticks -= $urandom_range(1, 7);
        for (int k = 0; k < n_ticks; k++) begin
          if ($urandom_range(0, 15) == 0)
            push_item(MODE_WRITE, pick_byte(), 1'($urandom_range(0, 1)));
          push_item(MODE_TICK, pick_byte(), 1'($urandom_range(0, 1)));
        end
      end else begin
        repeat ($urandom_range(3, 12))
          push_item(1'($urandom_range(0, 1)), pick_byte(), 1'($urandom_range(0, 1)));
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    idx = 0;
    while (idx < stim_items.size()) begin
      no_idle = (idx + CALM_TAIL >= stim_items.size());
      if (idx == pause_idx) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end
      gap = 0;
      if (calm_left > 0) begin
        calm_left--;
      end else if (!no_idle) begin
        case ($urandom_range(0, 39))
          0: calm_left = $urandom_range(20, 60);
          1, 2, 3, 4, 5, 6: gap = $urandom_range(1, 10);
          default: gap = 0;
        endcase
      end
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data <= stim_items[idx];
      do @(posedge clk); while (in_stall);
      idx++;
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
